### sv/assert_macros.svh
// Assertion helper macros for the tag frame parser checkers.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, masked while rst is high.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

### sv/hatf_pkg.sv
// Shared types, constants and byte classifier for the tag frame parser.
// No dependencies.
package hatf_pkg;

   localparam logic [7:0] START_MARK = 8'h02;
   localparam logic [7:0] END_MARK   = 8'h03;
   localparam int         FRAME_BYTES = 14;

   localparam logic [3:0] FILL_HUNT  = 4'd0;
   localparam logic [3:0] FILL_FIRST = 4'd1;
   localparam logic [3:0] FILL_LAST  = 4'(FRAME_BYTES - 1);
   localparam logic [3:0] FILL_ID_END = 4'd10;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_END  = 2'd1;
   localparam logic [1:0] STATUS_BAD_HEX = 2'd2;
   localparam logic [1:0] STATUS_BAD_SUM = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int ID_W = 40;

   // classified received word
   typedef struct packed {
      logic       is_start;
      logic       is_end;
      logic       hex_ok;
      logic [3:0] digit;
   } byte_class_type;

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type c;
      c.is_start = (b == START_MARK);
      c.is_end   = (b == END_MARK);
      c.hex_ok   = 1'b0;
      c.digit    = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin        // '0'..'9'
         c.hex_ok = 1'b1;
         c.digit  = b[3:0];
      end else if ((b >= 8'h41 && b <= 8'h46) ||  // 'A'..'F'
                   (b >= 8'h61 && b <= 8'h66)) begin // 'a'..'f'
         c.hex_ok = 1'b1;
         c.digit  = b[3:0] + 4'd9;
      end
      return c;
   endfunction

endpackage

### sv/hex_ascii_tag_frame_parser.sv
// Top level of the STX/ETX ASCII-hex tag frame parser.
// Depends on hatf_pkg, hatf_front, hatf_queue, hatf_back.
//
// Usage:
//  - req_* takes received serial words, one byte each. Bytes are skipped
//    until a start marker 0x02; then a fixed 14-byte frame is collected:
//    start, ten hex digits of tag ID, two hex digits of XOR checksum, end
//    marker 0x03. A start marker inside a frame is plain (non-hex) data.
//  - rsp_* carries one word per frame, on its 14th byte: the tag ID in
//    tdata (zero unless the frame is good) and a status in tuser
//    (0 ok, 1 missing end marker, 2 non-hex digit, 3 checksum mismatch).
//  - Throughput: one byte per cycle, sustained; req_tready stays high
//    while the four-entry queue between the classifier and the frame
//    sequencer has room.
//  - Path: the last frame byte passes through the front register, the queue
//    and the result register before rsp_tvalid rises.
//  - Receiver stall: the result register holds; the sequencer stops
//    only when it has a result to post, the queue fills, and req_tready
//    then drops. No word is lost or repeated.
//  - Reset (synchronous, active high) empties the pipeline and returns
//    the sequencer to hunting for a start marker.
module hex_ascii_tag_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [39:0] tag_id
   output logic [1:0]  rsp_tuser    // [1:0] frame_status
);

   // front -> queue
   logic                     f_valid, f_ready;
   hatf_pkg::byte_class_type f_item;
   // queue -> back
   logic                     q_valid, q_ready;
   hatf_pkg::byte_class_type q_item;

   // classify each byte and register it
   hatf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item_valid (f_valid),
      .item_ready (f_ready),
      .item       (f_item)
   );

   // decouples the classifier from result back-pressure
   hatf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   // frame sequencer and result register
   hatf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item_ready (q_ready),
      .item       (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_id     (rsp_tdata),
      .rsp_status (rsp_tuser)
   );

endmodule

### sv/hatf_front.sv
// Front stage: registers each received word with its classification.
// Depends on hatf_pkg.
module hatf_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   output logic                    item_valid,
   input  logic                    item_ready,
   output hatf_pkg::byte_class_type item
);

   logic                     valid_ff, valid_in;
   hatf_pkg::byte_class_type item_ff, item_in;
   logic                     take;

   assign req_tready = !valid_ff || item_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = hatf_pkg::classify(req_tdata);
      end else if (item_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### sv/hatf_queue.sv
// Short FIFO of classified words between front and back stages.
// Depends on hatf_pkg.
module hatf_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  hatf_pkg::byte_class_type in_item,
   output logic                     out_valid,
   input  logic                     out_ready,
   output hatf_pkg::byte_class_type out_item
);

   localparam logic [hatf_pkg::QPTR_W:0] DEPTH_CNT =
      (hatf_pkg::QPTR_W + 1)'(hatf_pkg::QUEUE_DEPTH);

   hatf_pkg::byte_class_type mem [hatf_pkg::QUEUE_DEPTH];
   logic [hatf_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [hatf_pkg::QPTR_W:0]   cnt_ff, cnt_in;
   logic                        push, pop;

   assign in_ready  = (cnt_ff != DEPTH_CNT);
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem[wr_ff] <= in_item;
      end
   end

endmodule

### sv/hatf_back.sv
// Back stage: frame sequencer, ID/checksum assembly and result register.
// Depends on hatf_pkg.
module hatf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   output logic                     item_ready,
   input  hatf_pkg::byte_class_type item,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [hatf_pkg::ID_W-1:0] rsp_id,
   output logic [1:0]               rsp_status
);

   logic [3:0]                fill_ff, fill_in;
   logic [hatf_pkg::ID_W-1:0] id_ff, id_in;
   logic [3:0]                hold_ff, hold_in;
   logic [7:0]                xor_ff, xor_in;
   logic [7:0]                check_ff, check_in;
   logic                      bad_ff, bad_in;
   logic                      out_valid_ff, out_valid_in;
   logic [hatf_pkg::ID_W-1:0] out_id_ff, out_id_in;
   logic [1:0]                out_status_ff, out_status_in;

   logic       pop;
   logic [3:0] d;
   logic [7:0] v;
   logic [1:0] status;

   // only the last frame byte needs a free result register
   assign item_ready = !out_valid_ff || rsp_tready || (fill_ff != hatf_pkg::FILL_LAST);
   assign pop        = item_valid && item_ready;
   assign d          = item.hex_ok ? item.digit : 4'd0;
   assign v          = {hold_ff, d};

   always_comb begin
      priority if (!item.is_end) begin
         status = hatf_pkg::STATUS_NO_END;
      end else if (bad_ff) begin
         status = hatf_pkg::STATUS_BAD_HEX;
      end else if (xor_ff != check_ff) begin
         status = hatf_pkg::STATUS_BAD_SUM;
      end else begin
         status = hatf_pkg::STATUS_OK;
      end
   end

   always_comb begin
      fill_in       = fill_ff;
      id_in         = id_ff;
      hold_in       = hold_ff;
      xor_in        = xor_ff;
      check_in      = check_ff;
      bad_in        = bad_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_id_in     = out_id_ff;
      out_status_in = out_status_ff;
      if (pop) begin
         if (fill_ff == hatf_pkg::FILL_HUNT) begin
            if (item.is_start) begin
               fill_in  = hatf_pkg::FILL_FIRST;
               id_in    = '0;
               hold_in  = '0;
               xor_in   = '0;
               check_in = '0;
               bad_in   = 1'b0;
            end
         end else if (fill_ff < hatf_pkg::FILL_LAST) begin
            bad_in  = bad_ff || !item.hex_ok;
            fill_in = fill_ff + 4'd1;
            if (fill_ff[0]) begin
               hold_in = d;
            end else if (fill_ff <= hatf_pkg::FILL_ID_END) begin
               id_in  = {id_ff[hatf_pkg::ID_W-9:0], v};
               xor_in = xor_ff ^ v;
            end else begin
               check_in = v;
            end
         end else begin
            fill_in       = hatf_pkg::FILL_HUNT;
            out_valid_in  = 1'b1;
            out_status_in = status;
            out_id_in     = (status == hatf_pkg::STATUS_OK) ? id_ff : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= hatf_pkg::FILL_HUNT;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
      id_ff         <= id_in;
      hold_ff       <= hold_in;
      xor_ff        <= xor_in;
      check_ff      <= check_in;
      bad_ff        <= bad_in;
      out_id_ff     <= out_id_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_id     = out_id_ff;
   assign rsp_status = out_status_ff;

endmodule

### sv/hatf_checker.sv
// Port-level checker for the tag frame parser, bound to the top level.
// Depends on hatf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hatf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // stalled result holds
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // failed frames carry a zero ID
   `ASSERT_CLK(a_fail_zero_id, clock, reset,
      rsp_tvalid && (rsp_tuser != hatf_pkg::STATUS_OK) |-> rsp_tdata == '0)

   // no result right after reset
   `ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_tvalid)

   // a frame needs 14 bytes: no result while only a new byte could have arrived
   `ASSERT_CLK(a_no_result_early, clock, reset, $past(reset) |=> !rsp_tvalid)

endmodule

bind hex_ascii_tag_frame_parser hatf_checker u_hatf_checker (.*);

### verif/tb_hex_ascii_tag_frame_parser.sv
// Self-checking bench for the STX/ETX ASCII-hex tag frame parser: random framed byte streams,
// a cycle-free frame predictor and an in-order check of every result word.
// Depends on hatf_pkg and hex_ascii_tag_frame_parser.
`timescale 1ns / 1ps

module tb_hex_ascii_tag_frame_parser;

   localparam int WORDS_TARGET = 1550;
   localparam int IDLE_LIMIT   = 5000;  // cycles with no handshake on either side
   localparam int DRAIN_CYCLES = 20;    // pipeline is three deep; generous margin

   typedef struct {
      logic [7:0] data;
      bit         drain_first;  // hold this word back until all reports are in
   } rx_word_type;

   typedef struct packed {
      logic [hatf_pkg::ID_W-1:0] tag;
      logic [1:0]                status;
   } tag_report_type;

   typedef enum logic [2:0] {
      FAULT_NONE = 3'b000,
      FAULT_END  = 3'b001,
      FAULT_HEX  = 3'b010,
      FAULT_SUM  = 3'b100
   } frame_fault_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = '0;    // [7:0] rx_byte
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [hatf_pkg::ID_W-1:0] rsp_tdata;        // [39:0] tag_id
   logic [1:0]                rsp_tuser;        // [1:0] frame_status

   hex_ascii_tag_frame_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Frame predictor: mirrors the parser one received word at a time
   // ---------------------------------------------------------------
   logic [3:0]                frame_pos;      // 0 while hunting for a start marker
   logic [hatf_pkg::ID_W-1:0] id_acc;
   logic [3:0]                hi_digit;
   logic [7:0]                sum_xor;
   logic [7:0]                sum_rx;
   logic                      saw_bad_digit;
   tag_report_type            reports_due[$];

   rx_word_type rx_words_q[$];
   int          words_queued = 0;
   int          words_sent = 0;
   int          mismatches = 0;

   function automatic logic ascii_hex_value(input logic [7:0] b, output logic [3:0] v);
      v = 4'd0;
      if (b >= "0" && b <= "9") v = 4'(b - 8'h30);
      else if (b >= "A" && b <= "F") v = 4'(b - 8'h37);
      else if (b >= "a" && b <= "f") v = 4'(b - 8'h57);
      else return 1'b0;
      return 1'b1;
   endfunction

   task automatic parse_rx_byte(input logic [7:0] b);
      logic [3:0]     nib;
      logic [7:0]     pair;
      tag_report_type rep;
      if (frame_pos == hatf_pkg::FILL_HUNT) begin
         if (b == hatf_pkg::START_MARK) begin
            frame_pos     = hatf_pkg::FILL_FIRST;
            id_acc        = '0;
            hi_digit      = '0;
            sum_xor       = '0;
            sum_rx        = '0;
            saw_bad_digit = 1'b0;
         end
      end else if (frame_pos < hatf_pkg::FILL_LAST) begin
         if (!ascii_hex_value(b, nib)) begin
            saw_bad_digit = 1'b1;
            nib = 4'd0;
         end
         if (frame_pos[0]) begin
            hi_digit = nib;
         end else begin
            pair = {hi_digit, nib};
            if (frame_pos <= hatf_pkg::FILL_ID_END) begin
               id_acc  = {id_acc[hatf_pkg::ID_W-9:0], pair};
               sum_xor = sum_xor ^ pair;
            end else begin
               sum_rx = pair;
            end
         end
         frame_pos = frame_pos + 4'd1;
      end else begin
         // end marker first, then digits, then checksum
         if (b != hatf_pkg::END_MARK) rep.status = hatf_pkg::STATUS_NO_END;
         else if (saw_bad_digit) rep.status = hatf_pkg::STATUS_BAD_HEX;
         else if (sum_xor != sum_rx) rep.status = hatf_pkg::STATUS_BAD_SUM;
         else rep.status = hatf_pkg::STATUS_OK;
         rep.tag = (rep.status == hatf_pkg::STATUS_OK) ? id_acc : '0;
         reports_due.push_back(rep);
         frame_pos = hatf_pkg::FILL_HUNT;
      end
   endtask

   // ---------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------
   function automatic logic [7:0] nibble_char(input logic [3:0] n, input bit upper);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (upper ? 8'h37 : 8'h57) + 8'(n);
   endfunction

   task automatic queue_word(input logic [7:0] b, input bit drain_first);
      rx_word_type w;
      w.data = b;
      w.drain_first = drain_first;
      rx_words_q.push_back(w);
      words_queued++;
   endtask

   task automatic queue_frame(input logic [2:0] faults, input bit drain_first);
      logic [7:0] fr [0:13];
      logic [7:0] idb;
      logic [7:0] sum;
      logic [3:0] dummy;
      int         pos;
      fr[0] = hatf_pkg::START_MARK;
      sum = '0;
      for (int i = 0; i < 5; i++) begin
         if ($urandom_range(0, 3) == 0) idb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         else idb = 8'($urandom);
         sum = sum ^ idb;
         fr[1 + 2 * i] = nibble_char(idb[7:4], 1'($urandom));
         fr[2 + 2 * i] = nibble_char(idb[3:0], 1'($urandom));
      end
      if (faults & FAULT_SUM) sum = sum ^ 8'($urandom_range(1, 255));
      fr[11] = nibble_char(sum[7:4], 1'($urandom));
      fr[12] = nibble_char(sum[3:0], 1'($urandom));
      fr[13] = hatf_pkg::END_MARK;
      if (faults & FAULT_END)
         do fr[13] = 8'($urandom); while (fr[13] == hatf_pkg::END_MARK);
      if (faults & FAULT_HEX) begin
         pos = $urandom_range(1, 12);
         do fr[pos] = 8'($urandom); while (ascii_hex_value(fr[pos], dummy));
      end
      for (int i = 0; i < 14; i++) queue_word(fr[i], drain_first && i == 0);
   endtask

   // idle draw: mostly 0..14 cycles, with occasional runs of back-to-back words
   function automatic int draw_gap(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         quiet_left = $urandom_range(15, 60);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   // ---------------------------------------------------------------
   // Driver
   // ---------------------------------------------------------------
   rx_word_type staged_word;
   bit          word_staged = 1'b0;
   int          send_wait = 0;
   int          send_quiet = 0;

   always @(posedge clock) begin
      logic       valid_n;
      logic [7:0] data_n;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         valid_n = req_tvalid;
         data_n  = req_tdata;
         if (req_tvalid && req_tready) begin
            parse_rx_byte(req_tdata);
            words_sent++;
            valid_n = 1'b0;
         end
         if (!valid_n) begin
            if (!word_staged && rx_words_q.size() > 0 &&
                !(rx_words_q[0].drain_first && reports_due.size() != 0)) begin
               staged_word = rx_words_q.pop_front();
               send_wait   = draw_gap(send_quiet);
               word_staged = 1'b1;
            end
            if (word_staged) begin
               if (send_wait == 0) begin
                  valid_n     = 1'b1;
                  data_n      = staged_word.data;
                  word_staged = 1'b0;
               end else begin
                  send_wait--;
               end
            end
         end
         req_tvalid <= valid_n;
         req_tdata  <= data_n;
      end
   end

   // ---------------------------------------------------------------
   // Monitor / checker
   // ---------------------------------------------------------------
   int sink_wait = 0;
   int sink_quiet = 0;

   task automatic check_tag_report();
      tag_report_type want;
      if (reports_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result word: tag %h status %0d", rsp_tdata, rsp_tuser);
         return;
      end
      want = reports_due.pop_front();
      if (rsp_tdata !== want.tag || rsp_tuser !== want.status) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result mismatch: tag exp %h got %h, status exp %0d got %0d",
                     want.tag, rsp_tdata, want.status, rsp_tuser);
      end
   endtask

   always @(posedge clock) begin
      logic ready_n;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_wait = $urandom_range(0, 14);
      end else begin
         ready_n = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            check_tag_report();
            sink_wait = draw_gap(sink_quiet);
            ready_n = 1'b0;
         end
         if (!ready_n) begin
            if (sink_wait == 0) ready_n = 1'b1;
            else sink_wait--;
         end
         rsp_tready <= ready_n;
      end
   end

   // watchdog: no handshake on either side for too long
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("hex_ascii_tag_frame_parser regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      logic [2:0] faults;
      bit         first_random;
      frame_pos     = hatf_pkg::FILL_HUNT;
      id_acc        = '0;
      hi_digit      = '0;
      sum_xor       = '0;
      sum_rx        = '0;
      saw_bad_digit = 1'b0;
      first_random  = 1'b1;

      // directed: junk while hunting, all-ones ID in mixed case, then a frame
      // with a start marker in the middle that must not restart it
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b0);
      queue_word(hatf_pkg::START_MARK, 1'b0);
      for (int i = 0; i < 12; i++) queue_word(i[0] ? "f" : "F", 1'b0);
      queue_word(hatf_pkg::END_MARK, 1'b0);
      queue_word(hatf_pkg::START_MARK, 1'b0);
      queue_word("0", 1'b0);
      queue_word("0", 1'b0);
      queue_word(hatf_pkg::START_MARK, 1'b0);
      for (int i = 0; i < 9; i++) queue_word("0", 1'b0);
      queue_word(hatf_pkg::END_MARK, 1'b0);

      // random: mostly well-formed frames, some with faults, noise between
      while (words_queued < WORDS_TARGET) begin
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0)
            queue_word(8'($urandom), 1'b0);
         faults = ($urandom_range(0, 99) < 60) ? FAULT_NONE : 3'($urandom_range(1, 7));
         queue_frame(faults, first_random || $urandom_range(0, 24) == 0);
         first_random = 1'b0;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      wait (words_sent == words_queued);
      wait (reports_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && reports_due.size() == 0)
         $display("hex_ascii_tag_frame_parser regression: pass");
      else
         $display("hex_ascii_tag_frame_parser regression: fail");
      $finish;
   end

endmodule
